### sv/sods_pkg.sv
// Shared types, constants and helpers for the slot occupancy debounce block.
// No dependencies; imported by sods_slot_bank and slot_occupancy_debounce_select.

package sods_pkg;

	// Tray geometry
	localparam int SLOTS     = 10;                  // slots tracked
	localparam int IN_W      = 10;                  // raw occupancy field width
	localparam int STATUS_W  = 10;                  // stable status field width
	localparam int SEL_OUT_W = 4;                   // selected slot field width
	localparam int SEL_W     = $clog2(SLOTS + 1);   // holds 0..SLOTS

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AI_ENABLED    = 2'd0,
		REG_SLOT_CONFIRM  = 2'd1,
		REG_FULL_CONFIRM  = 2'd2
	} cfg_reg_t;

	// Counter types
	typedef logic [3:0] run_t;
	typedef logic [7:0] full_run_t;

	localparam run_t      RUN_MAX  = 4'hF;
	localparam full_run_t FULL_MAX = 8'hFF;

	// Reset values of the registers
	localparam logic      AI_ENABLED_RST   = 1'b1;
	localparam run_t      SLOT_CONFIRM_RST = 4'd2;
	localparam full_run_t FULL_CONFIRM_RST = 8'd10;

	// Saturating increments
	function automatic run_t run_inc(input run_t v);
		return (v == RUN_MAX) ? v : run_t'(v + 4'd1);
	endfunction

	function automatic full_run_t full_inc(input full_run_t v);
		return (v == FULL_MAX) ? v : full_run_t'(v + 8'd1);
	endfunction

endpackage

### sv/sods_slot_bank.sv
// Per-slot debounce: empty and occupied run counters plus the stable state.
// Depends on sods_pkg.

module sods_slot_bank import sods_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,     // process the frame in seen this cycle
	input  logic [SLOTS-1:0] seen,        // raw occupancy of the frame
	input  run_t             confirm,     // equal frames needed to flip
	output logic [SLOTS-1:0] stable_nxt   // stable state after this frame
);

	run_t             occ_run_q [SLOTS];
	run_t             emp_run_q [SLOTS];
	run_t             occ_run_nxt [SLOTS];
	run_t             emp_run_nxt [SLOTS];
	logic [SLOTS-1:0] stable_q;

	// Next counter values and stable state, all slots in parallel
	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			if (seen[k]) begin
				occ_run_nxt[k] = run_inc(occ_run_q[k]);
				emp_run_nxt[k] = '0;
				stable_nxt[k]  = (occ_run_nxt[k] >= confirm) ? 1'b1 : stable_q[k];
			end else begin
				emp_run_nxt[k] = run_inc(emp_run_q[k]);
				occ_run_nxt[k] = '0;
				stable_nxt[k]  = (emp_run_nxt[k] >= confirm) ? 1'b0 : stable_q[k];
			end
		end
	end

	// State registers, all slots start empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				occ_run_q[k] <= '0;
				emp_run_q[k] <= '0;
			end
			stable_q <= '0;
		end else if (advance) begin
			for (int k = 0; k < SLOTS; k++) begin
				occ_run_q[k] <= occ_run_nxt[k];
				emp_run_q[k] <= emp_run_nxt[k];
			end
			stable_q <= stable_nxt;
		end
	end

endmodule

### sv/slot_occupancy_debounce_select.sv
// Top level: config registers, input stage, slot debounce, empty-slot select, tray-full pulse.
// Depends on sods_pkg and sods_slot_bank.
//
//  channel | signals                                        | transfer when
//  --------+------------------------------------------------+---------------------
//  in      | in_valid, in_ready, occupancy_bits             | in_valid & in_ready
//  out     | out_valid, out_ready, free_slot,               | out_valid & out_ready
//          | occ_status, tray_full_pulse                    |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | cfg_valid & cfg_ready
//
// One frame per cycle sustained while the output is not stalled. A frame passes the input
// register, then the result register, from which its result is offered; an output stall
// holds it in the input register. The stage between the two registers holds the per-slot
// counter update, the lowest-empty search and the full-run counter.
// Frames taken while ai_enabled is low are dropped at the input register.
// Output stalls back up through the input stage; cfg_ready is always high.
// Reset clears counters, valid flags, stable status (all slots empty); cfg regs to defaults.

module slot_occupancy_debounce_select import sods_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input frames
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [IN_W-1:0]       occupancy_bits,
	// results
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SEL_OUT_W-1:0]  free_slot,
	output logic [STATUS_W-1:0]   occ_status,
	output logic                  tray_full_pulse,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                  ai_enabled_q;
	run_t                  slot_confirm_q;
	full_run_t             full_confirm_q;

	logic                  valid_s1;
	logic [IN_W-1:0]       bits_s1;
	logic                  advance;

	logic [SLOTS-1:0]      seen;
	logic [SLOTS-1:0]      stable_nxt;
	logic [SEL_W-1:0]      sel;
	logic                  tray_full;
	full_run_t             full_run_q;
	full_run_t             full_run_nxt;
	logic                  change_sent_q;
	logic                  pulse;
	logic [STATUS_W-1:0]   status;

	logic                  out_valid_q;
	logic [SEL_OUT_W-1:0]  sel_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  pulse_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ai_enabled_q   <= AI_ENABLED_RST;
			slot_confirm_q <= SLOT_CONFIRM_RST;
			full_confirm_q <= FULL_CONFIRM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_AI_ENABLED:   ai_enabled_q   <= cfg_data[0];
				REG_SLOT_CONFIRM: slot_confirm_q <= cfg_data[3:0];
				REG_FULL_CONFIRM: full_confirm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && ai_enabled_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bits_s1 <= occupancy_bits;
		end
	end

	// Slots without an input bit always read empty
	for (genvar k = 0; k < SLOTS; k++) begin : g_seen
		if (k < IN_W) begin : g_bit
			assign seen[k] = bits_s1[k];
		end else begin : g_none
			assign seen[k] = 1'b0;
		end
	end

	sods_slot_bank u_slot_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.seen       (seen),
		.confirm    (slot_confirm_q),
		.stable_nxt (stable_nxt)
	);

	// Lowest stable empty slot, numbered from 1
	always_comb begin
		sel = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (!stable_nxt[k]) begin
				sel = SEL_W'(k + 1);
			end
		end
	end

	assign tray_full = &stable_nxt;

	// Status vector at field width
	for (genvar j = 0; j < STATUS_W; j++) begin : g_status
		if (j < SLOTS) begin : g_slot
			assign status[j] = stable_nxt[j];
		end else begin : g_pad
			assign status[j] = 1'b0;
		end
	end

	// Full-tray run and one-shot pulse
	assign full_run_nxt = tray_full ? full_inc(full_run_q) : '0;
	assign pulse        = tray_full && (full_run_nxt >= full_confirm_q) && !change_sent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_run_q    <= '0;
			change_sent_q <= 1'b0;
		end else if (advance) begin
			full_run_q    <= full_run_nxt;
			change_sent_q <= tray_full && (change_sent_q || pulse);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sel_q    <= SEL_OUT_W'(sel);
			status_q <= status;
			pulse_q  <= pulse;
		end
	end

	assign out_valid       = out_valid_q;
	assign free_slot       = sel_q;
	assign occ_status      = status_q;
	assign tray_full_pulse = pulse_q;

endmodule

### test/slot_occupancy_debounce_select_test.sv
// Self-checking testbench for slot_occupancy_debounce_select: debounce, empty-slot select
// and tray-full pulse checked against an in-bench predictor. Depends on sods_pkg and the RTL.
`timescale 1ns / 1ps

module slot_occupancy_debounce_select_test import sods_pkg::*; ();

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 6;     // two-stage pipe plus margin
	localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
	localparam int PHASE_FRAMES = 50;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// One expected result per processed frame
	typedef struct packed {
		logic [SEL_OUT_W-1:0] sel;
		logic [STATUS_W-1:0]  status;
		logic                 pulse;
	} slot_report_t;

	// Tray predictor and scoreboard
	class tray_scoreboard;
		logic                 ai_on;
		run_t                 slot_thresh;
		full_run_t            full_thresh;
		run_t                 empty_run [SLOTS];
		run_t                 occ_run [SLOTS];
		logic [SLOTS-1:0]     stable;
		full_run_t            full_cnt;
		logic                 pulse_sent;
		slot_report_t         pending_reports [$];
		int                   errors;
		int                   frames;
		int                   checked;
		int                   pulses;

		function new();
			ai_on       = 1'b1;
			slot_thresh = 4'd2;
			full_thresh = 8'd10;
			for (int k = 0; k < SLOTS; k++) begin
				empty_run[k] = '0;
				occ_run[k]   = '0;
			end
			stable     = '0;
			full_cnt   = '0;
			pulse_sent = 1'b0;
			errors     = 0;
			frames     = 0;
			checked    = 0;
			pulses     = 0;
		endfunction

		// Register write as the block sees it; unknown index is dropped
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_AI_ENABLED:   ai_on       = data[0];
				REG_SLOT_CONFIRM: slot_thresh = data[3:0];
				REG_FULL_CONFIRM: full_thresh = data;
				default: ;
			endcase
		endfunction

		// Accepted frame: update debounce state and queue the expected report
		function void note_frame(logic [IN_W-1:0] bits);
			slot_report_t rep;
			if (!ai_on)
				return;
			rep = '0;
			for (int k = 0; k < SLOTS; k++) begin
				if (bits[k]) begin
					occ_run[k]   = (occ_run[k] == RUN_MAX) ? occ_run[k] : occ_run[k] + 4'd1;
					empty_run[k] = '0;
					if (occ_run[k] >= slot_thresh)
						stable[k] = 1'b1;
				end else begin
					empty_run[k] = (empty_run[k] == RUN_MAX) ? empty_run[k] : empty_run[k] + 4'd1;
					occ_run[k]   = '0;
					if (empty_run[k] >= slot_thresh)
						stable[k] = 1'b0;
				end
			end
			// lowest stable empty slot, numbered from 1
			for (int k = 0; k < SLOTS; k++) begin
				if (stable[k])
					rep.status[k] = 1'b1;
				else if (rep.sel == '0)
					rep.sel = SEL_OUT_W'(k + 1);
			end
			// full-tray run and one-shot pulse
			if (rep.sel == '0) begin
				full_cnt = (full_cnt == FULL_MAX) ? full_cnt : full_cnt + 8'd1;
				if (full_cnt >= full_thresh && !pulse_sent) begin
					rep.pulse  = 1'b1;
					pulse_sent = 1'b1;
				end
			end else begin
				full_cnt   = '0;
				pulse_sent = 1'b0;
			end
			frames++;
			pending_reports.insert(pending_reports.size(), rep);
		endfunction

		// Result transfer: compare with the oldest expected report
		function void check_result(logic [SEL_OUT_W-1:0] sel, logic [STATUS_W-1:0] status,
				logic pulse);
			slot_report_t exp_rep;
			if (pending_reports.size() == 0) begin
				$error("result with no frame pending: free_slot %0d occ_status %h",
					sel, status);
				errors++;
				return;
			end
			exp_rep = pending_reports[0];
			pending_reports.delete(0);
			checked++;
			if (pulse)
				pulses++;
			if (sel !== exp_rep.sel) begin
				$error("free_slot: expected %0d, actual %0d", exp_rep.sel, sel);
				errors++;
			end
			if (status !== exp_rep.status) begin
				$error("occ_status: expected %h, actual %h", exp_rep.status, status);
				errors++;
			end
			if (pulse !== exp_rep.pulse) begin
				$error("tray_full_pulse: expected %0d, actual %0d", exp_rep.pulse, pulse);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [IN_W-1:0]       occupancy_bits = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SEL_OUT_W-1:0]  free_slot;
	logic [STATUS_W-1:0]   occ_status;
	logic                  tray_full_pulse;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tray_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_done     = 0;
	int hold_left     = 0;
	int cfg_writes    = 0;

	slot_occupancy_debounce_select dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.occupancy_bits  (occupancy_bits),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.free_slot       (free_slot),
		.occ_status      (occ_status),
		.tray_full_pulse (tray_full_pulse),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_done != hold_req) begin
			hold_done++;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(free_slot, occ_status, tray_full_pulse);
	end

	// Offer one frame, with a random gap first; returns at the transfer edge
	task automatic send_frame(input logic [IN_W-1:0] bits);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid       <= 1'b1;
		occupancy_bits <= bits;
		@(posedge clk iff in_ready);
		sb.note_frame(bits);
	endtask

	// Lower valid, then wait for every pending report and the pipe to empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk iff cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Held patterns with occasional single-bit flicker
	task automatic run_phase(input int count);
		logic [IN_W-1:0] held;
		logic [IN_W-1:0] flick;
		int              run_len;
		int              sent;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(4))
				0: held = IN_W'($urandom);
				1: held = '1;
				2: held = ~(IN_W'(1) << $urandom_range(IN_W - 1));
				3: held = IN_W'($urandom) & IN_W'($urandom);
				default: held = '0;
			endcase
			run_len = $urandom_range(1, 18);
			if (run_len > count - sent)
				run_len = count - sent;
			repeat (run_len) begin
				flick = ($urandom_range(9) == 0) ? IN_W'(1) << $urandom_range(IN_W - 1) : '0;
				send_frame(held ^ flick);
				sent++;
			end
		end
	endtask

	task automatic send_run(input logic [IN_W-1:0] bits, input int count);
		repeat (count) send_frame(bits);
	endtask

	// Main sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: two frames to confirm, ten full frames to pulse
		send_idle_pct = 24;
		recv_idle_pct = 50;
		send_frame(10'h3FF);
		send_frame(10'h3FF);
		send_frame(10'h2AA);
		send_frame(10'h155);
		send_frame(10'h155);
		send_frame(10'h000);
		send_frame(10'h000);
		drain();

		// zero thresholds act like one; upper data bits of the slot register ignored
		write_reg(REG_SLOT_CONFIRM, 8'hF0);
		write_reg(REG_FULL_CONFIRM, 8'h00);
		send_frame(10'h3FF);
		send_frame(10'h3FF);
		send_frame(10'h1FF);
		send_frame(10'h3FF);
		send_frame(10'h3FE);
		send_frame(10'h001);
		drain();

		// AI mode off: frames dropped; unknown index write changes nothing
		write_reg(REG_AI_ENABLED, 8'hFE);
		write_reg(REG_UNUSED, 8'hFF);
		send_frame(10'h3FF);
		send_frame(10'h2AA);
		drain();

		// threshold one: immediate follow and pulse on the first full frame
		write_reg(REG_AI_ENABLED, 8'h01);
		write_reg(REG_SLOT_CONFIRM, 8'h01);
		write_reg(REG_FULL_CONFIRM, 8'h01);
		send_frame(10'h3FF);
		send_frame(10'h3FF);
		send_frame(10'h000);
		drain();

		// random phases under three idling mixes
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 50 : 0;
			recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 24 : 0;
			for (int ph = 0; ph < 4; ph++) begin
				drain();
				case (ph)
					0: begin
						write_reg(REG_SLOT_CONFIRM, {CFG_DATA_W'($urandom) & 8'hF0} | 8'h01);
						write_reg(REG_FULL_CONFIRM, 8'h01);
					end
					1: begin
						write_reg(REG_SLOT_CONFIRM, 8'h0F);
						write_reg(REG_FULL_CONFIRM, 8'hFF);
					end
					2: begin
						write_reg(REG_SLOT_CONFIRM, CFG_DATA_W'($urandom));
						write_reg(REG_FULL_CONFIRM, CFG_DATA_W'($urandom_range(0, 24)));
					end
					default: begin
						write_reg(REG_AI_ENABLED, CFG_DATA_W'($urandom) & 8'hFE);
						write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
						run_phase(8);
						drain();
						write_reg(REG_AI_ENABLED, CFG_DATA_W'($urandom) | 8'h01);
						write_reg(REG_SLOT_CONFIRM, CFG_DATA_W'($urandom_range(2, 5)));
						write_reg(REG_FULL_CONFIRM, CFG_DATA_W'($urandom_range(2, 12)));
					end
				endcase
				// receiver stops for a long stretch while frames keep coming
				if (mode == 2 && ph == 0)
					hold_req++;
				// long full run saturates both run counters and reaches the top threshold
				if (mode == 2 && ph == 1) begin
					send_run(10'h000, 20);
					send_run(10'h3FF, 270);
				end
				run_phase(PHASE_FRAMES);
			end
		end

		drain();
		$display("Covered %0d processed frames, %0d results checked, %0d tray pulses,",
			sb.frames, sb.checked, sb.pulses);
		$display("  %0d register writes, three idling mixes and one long receiver stall",
			cfg_writes);
		if (sb.errors == 0 && sb.pending_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
sv/sods_pkg.sv
sv/sods_slot_bank.sv
sv/slot_occupancy_debounce_select.sv
test/slot_occupancy_debounce_select_test.sv
